// ===== hw/rtl/v3alu_pkg.sv =====
// Shared codes, latencies and saturating round helpers for the vector unit.
package v3alu_pkg;

	localparam logic [3:0] OP_ADD    = 4'd0;
	localparam logic [3:0] OP_SUB    = 4'd1;
	localparam logic [3:0] OP_CROSS  = 4'd2;
	localparam logic [3:0] OP_DOT    = 4'd3;
	localparam logic [3:0] OP_SCALE  = 4'd4;
	localparam logic [3:0] OP_SDIV   = 4'd5;
	localparam logic [3:0] OP_NEG    = 4'd6;
	localparam logic [3:0] OP_EMUL   = 4'd7;
	localparam logic [3:0] OP_EDIV   = 4'd8;
	localparam logic [3:0] OP_LENGTH = 4'd9;
	localparam logic [3:0] OP_NORM   = 4'd10;
	localparam logic [3:0] OP_CLAMP  = 4'd11;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 48;
	localparam int SQRT_LAT   = SQRT_STEPS + 1;
	localparam int DIV_LAT    = DIV_STEPS + 1;
	localparam int LATENCY    = SQRT_LAT + DIV_LAT + 3;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] val;
		logic        ov;
	} rnd_t;

	function automatic logic [50:0] sx51(input logic [31:0] a);
		return {{19{a[31]}}, a};
	endfunction

	function automatic logic [65:0] sx66(input logic [63:0] a);
		return {{2{a[63]}}, a};
	endfunction

	// Saturate a wide two's complement value to 32 bits.
	function automatic rnd_t sat_w(input logic [50:0] v);
		rnd_t r;
		r.ov  = !((&v[50:31]) || !(|v[50:31]));
		r.val = r.ov ? (v[50] ? S32_MIN : S32_MAX) : v[31:0];
		return r;
	endfunction

	// Round Q32.32 to Q16.16, nearest with ties away from zero, then saturate.
	function automatic rnd_t rnd_sat(input logic [65:0] t);
		logic [49:0] h;
		logic [15:0] l;
		logic        inc;
		h   = t[65:16];
		l   = t[15:0];
		inc = h[49] ? (l[15] & (|l[14:0])) : l[15];
		return sat_w({h[49], h} + {50'd0, inc});
	endfunction

endpackage

// ===== hw/rtl/v3alu_lane.sv =====
// One product lane: two multipliers, then rounding of the first product, or of their difference for cross.
module v3alu_lane import v3alu_pkg::*; (
	input  logic               clk,
	input  logic        [3:0]  op,
	input  logic signed [31:0] a_i,
	input  logic signed [31:0] a_j,
	input  logic signed [31:0] a_k,
	input  logic signed [31:0] b_i,
	input  logic signed [31:0] b_j,
	input  logic signed [31:0] b_k,
	input  logic signed [31:0] sc,
	output logic        [63:0] prod_s1,
	output rnd_t               res_s2
);

	logic signed [31:0] x0, y0;
	logic signed [63:0] p0_s1, p1_s1;
	logic               cr_s1;

	always_comb begin
		x0 = a_i;
		y0 = b_i;
		case (op)
			OP_CROSS: begin
				x0 = a_j;
				y0 = b_k;
			end
			OP_SCALE: y0 = sc;
			OP_LENGTH, OP_NORM: y0 = a_i;
			default: y0 = b_i;
		endcase
	end

	always_ff @(posedge clk) begin
		p0_s1  <= x0 * y0;
		p1_s1  <= a_k * b_j;
		cr_s1  <= (op == OP_CROSS);
		res_s2 <= rnd_sat(sx66(p0_s1) - (cr_s1 ? sx66(p1_s1) : 66'd0));
	end

	assign prod_s1 = p0_s1;

endmodule

// ===== hw/rtl/v3alu_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, rounded to nearest.
module v3alu_sqrt import v3alu_pkg::*; (
	input  logic        clk,
	input  logic [63:0] rad,
	output logic [32:0] len
);

	typedef struct packed {
		logic [63:0] x;
		logic [33:0] rem;
		logic [31:0] root;
	} sstg_t;

	sstg_t st0;
	sstg_t st [1:SQRT_STEPS];

	assign st0 = '{x: rad, rem: 34'd0, root: 32'd0};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		sstg_t       cur;
		logic [35:0] rem4, trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign cur = st0;
		end else begin : g_next
			assign cur = st[k];
		end
		always_comb begin
			rem4  = {cur.rem, cur.x[63:62]};
			trial = {2'b00, cur.root, 2'b01};
			ge    = (rem4 >= trial);
		end
		always_ff @(posedge clk) begin
			st[k+1].x    <= {cur.x[61:0], 2'b00};
			st[k+1].rem  <= ge ? 34'(rem4 - trial) : rem4[33:0];
			st[k+1].root <= {cur.root[30:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		len <= {1'b0, st[SQRT_STEPS].root} +
			{32'd0, (st[SQRT_STEPS].rem > {2'b00, st[SQRT_STEPS].root})};
	end

endmodule

// ===== hw/rtl/v3alu_div.sv =====
// Pipelined restoring divider: rounded, saturated Q16.16 quotient.
module v3alu_div import v3alu_pkg::*; (
	input  logic        clk,
	input  logic [31:0] num,
	input  logic [33:0] den,
	output logic [31:0] q,
	output logic        dz,
	output logic        ov
);

	typedef struct packed {
		logic [47:0] nq;
		logic [33:0] rem;
		logic [32:0] ud;
		logic        neg;
		logic        an;
		logic        az;
	} dstg_t;

	dstg_t       st0;
	dstg_t       st [1:DIV_STEPS];
	logic [31:0] ua;
	logic [33:0] uden;

	always_comb begin
		ua   = num[31] ? 32'(-num) : num;
		uden = den[33] ? 34'(-den) : den;
	end

	assign st0 = '{nq: {ua, 16'd0}, rem: 34'd0, ud: uden[32:0],
		neg: num[31] ^ den[33], an: num[31], az: (num == 32'd0)};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		dstg_t       cur;
		logic [34:0] rem2;
		logic        ge;
		if (k == 0) begin : g_first
			assign cur = st0;
		end else begin : g_next
			assign cur = st[k];
		end
		always_comb begin
			rem2 = {cur.rem, cur.nq[47]};
			ge   = (rem2 >= {2'b00, cur.ud});
		end
		always_ff @(posedge clk) begin
			st[k+1] <= '{nq: {cur.nq[46:0], ge},
				rem: ge ? 34'(rem2 - {2'b00, cur.ud}) : rem2[33:0],
				ud: cur.ud, neg: cur.neg, an: cur.an, az: cur.az};
		end
	end

	logic [48:0] qr;
	logic [50:0] sv;
	rnd_t        sr;

	always_comb begin
		qr = {1'b0, st[DIV_STEPS].nq} +
			{48'd0, ({st[DIV_STEPS].rem, 1'b0} >= {2'b00, st[DIV_STEPS].ud})};
		sv = st[DIV_STEPS].neg ? 51'(-{2'b00, qr}) : {2'b00, qr};
		sr = sat_w(sv);
	end

	always_ff @(posedge clk) begin
		if (st[DIV_STEPS].ud == 33'd0) begin
			q  <= st[DIV_STEPS].az ? 32'd0 : (st[DIV_STEPS].an ? S32_MIN : S32_MAX);
			dz <= 1'b1;
			ov <= 1'b0;
		end else begin
			q  <= sr.val;
			dz <= 1'b0;
			ov <= sr.ov;
		end
	end

endmodule

// ===== hw/rtl/vec3_arithmetic_unit_core.sv =====
// Top level of the Q16.16 three-component vector unit.
//
// Usage: drive the operation code, vectors A and B, the scalar, the clamp
// index and bounds, and raise start for one cycle; a beat is taken at every
// rising edge where start is high and busy is low. Busy never rises: the
// unit is a fixed pipeline and takes a new beat every cycle.
// Each result beat appears on r_x, r_y, r_z, scalar_out and status with done
// high for exactly one cycle, in order of arrival. The receiver cannot stall;
// sample on done. Each beat passes through the chain: the lane product and
// rounding registers, the bit-per-stage square root (its result feeds
// normalize), the per-lane restoring dividers and one output register.
// Every operation travels the whole chain, so latency is the same for all.
// Three lanes handle the x, y and z elements side by side; a merging stage
// forms dot sums and the sum of squares, and the output register settles
// the final status. Reset clears only the valid chain and done; beats in
// flight are dropped.
module vec3_arithmetic_unit_core import v3alu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [3:0]  operation,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] scalar_in,
	input  logic        [1:0]  component_index,
	input  logic signed [31:0] lower_bound,
	input  logic signed [31:0] upper_bound,
	output logic               done,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] scalar_out,
	output logic        [1:0]  status
);

	typedef struct packed {
		logic [3:0]       op;
		logic [2:0][31:0] a;
		logic [2:0][31:0] den;
		logic [2:0][31:0] er;
		logic [31:0]      eso;
		logic             eov;
	} pay1_t;

	typedef struct packed {
		logic [3:0]       op;
		logic [2:0][31:0] er;
		logic [31:0]      eso;
		logic             eov;
		logic             lz;
	} pay2_t;

	logic              acc;
	logic [31:0]       ain [3];
	logic [31:0]       bin [3];
	logic [63:0]       prod_s1 [3];
	rnd_t              lres_s2 [3];

	// Stage 1 and 2 registers of the merging side
	logic              v_s1, v_s2;
	logic [3:0]        op_s1, op_s2;
	logic [2:0][31:0]  a_s1, b_s1, a_s2, den_s2, tr_s2;
	logic [31:0]       sc_s1, lo_s1, hi_s1;
	logic [1:0]        idx_s1;
	logic              tov_s2;
	rnd_t              dot_s2;
	logic [63:0]       sq_s2;

	logic [32:0]       len;
	pay1_t             p1_in;
	pay1_t             p1_q [SQRT_LAT];
	logic              v1_q [SQRT_LAT];
	pay2_t             p2_in;
	pay2_t             p2_q [DIV_LAT];
	logic              v2_q [DIV_LAT];
	logic [31:0]       dq [3];
	logic              ddz [3];
	logic              dov [3];

	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign ain  = '{a_x, a_y, a_z};
	assign bin  = '{b_x, b_y, b_z};

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3alu_lane u_lane (
			.clk     (clk),
			.op      (operation),
			.a_i     (ain[i]),
			.a_j     (ain[(i+1)%3]),
			.a_k     (ain[(i+2)%3]),
			.b_i     (bin[i]),
			.b_j     (bin[(i+1)%3]),
			.b_k     (bin[(i+2)%3]),
			.sc      (scalar_in),
			.prod_s1 (prod_s1[i]),
			.res_s2  (lres_s2[i])
		);
	end

	// Stage 1: hold the operands beside the lane products
	always_ff @(posedge clk) begin
		op_s1  <= operation;
		a_s1   <= {a_z, a_y, a_x};
		b_s1   <= {b_z, b_y, b_x};
		sc_s1  <= scalar_in;
		lo_s1  <= lower_bound;
		hi_s1  <= upper_bound;
		idx_s1 <= component_index;
	end

	// Stage 2: element-wise add, subtract, negate, clamp; dot sum; sum of squares; divider denominators
	always_ff @(posedge clk) begin
		rnd_t t;
		logic tacc;
		tacc = 1'b0;
		for (int i = 0; i < 3; i++) begin
			case (op_s1)
				OP_ADD:  t = sat_w(sx51(a_s1[i]) + sx51(b_s1[i]));
				OP_SUB:  t = sat_w(sx51(a_s1[i]) - sx51(b_s1[i]));
				OP_NEG:  t = sat_w(51'(-sx51(a_s1[i])));
				OP_CLAMP: begin
					t.ov  = 1'b0;
					t.val = a_s1[i];
					if (idx_s1 == 2'(i)) begin
						if ($signed(a_s1[i]) < $signed(lo_s1))
							t.val = lo_s1;
						else if ($signed(a_s1[i]) > $signed(hi_s1))
							t.val = hi_s1;
					end
				end
				default: t = '0;
			endcase
			tr_s2[i] <= t.val;
			if (t.ov)
				tacc = 1'b1;
			den_s2[i] <= (op_s1 == OP_SDIV) ? sc_s1 : b_s1[i];
		end
		tov_s2 <= tacc;
		op_s2  <= op_s1;
		a_s2   <= a_s1;
		dot_s2 <= rnd_sat(sx66(prod_s1[0]) + sx66(prod_s1[1]) + sx66(prod_s1[2]));
		sq_s2  <= prod_s1[0] + prod_s1[1] + prod_s1[2];
	end

	// Merge lane and element-wise results into the early result
	always_comb begin
		p1_in     = '0;
		p1_in.op  = op_s2;
		p1_in.a   = a_s2;
		p1_in.den = den_s2;
		case (op_s2)
			OP_CROSS, OP_SCALE, OP_EMUL: begin
				for (int i = 0; i < 3; i++)
					p1_in.er[i] = lres_s2[i].val;
				p1_in.eov = lres_s2[0].ov | lres_s2[1].ov | lres_s2[2].ov;
			end
			OP_DOT: begin
				p1_in.eso = dot_s2.val;
				p1_in.eov = dot_s2.ov;
			end
			OP_ADD, OP_SUB, OP_NEG, OP_CLAMP: begin
				p1_in.er  = tr_s2;
				p1_in.eov = tov_s2;
			end
			default: p1_in.eov = 1'b0;
		endcase
	end

	v3alu_sqrt u_sqrt (
		.clk (clk),
		.rad (sq_s2),
		.len (len)
	);

	// Length result and divider feed, aligned with the square root output
	always_comb begin
		rnd_t ls;
		ls        = sat_w({18'd0, len});
		p2_in     = '0;
		p2_in.op  = p1_q[SQRT_LAT-1].op;
		p2_in.er  = p1_q[SQRT_LAT-1].er;
		p2_in.eso = p1_q[SQRT_LAT-1].eso;
		p2_in.eov = p1_q[SQRT_LAT-1].eov;
		p2_in.lz  = (len == 33'd0);
		if (p1_q[SQRT_LAT-1].op == OP_LENGTH) begin
			p2_in.eso = ls.val;
			p2_in.eov = ls.ov;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_div
		logic [33:0] dden;
		assign dden = (p1_q[SQRT_LAT-1].op == OP_NORM) ? {1'b0, len} :
			{{2{p1_q[SQRT_LAT-1].den[i][31]}}, p1_q[SQRT_LAT-1].den[i]};
		v3alu_div u_div (
			.clk (clk),
			.num (p1_q[SQRT_LAT-1].a[i]),
			.den (dden),
			.q   (dq[i]),
			.dz  (ddz[i]),
			.ov  (dov[i])
		);
	end

	// Payload delay lines beside the square root and the dividers
	always_ff @(posedge clk) begin
		p1_q[0] <= p1_in;
		for (int k = 1; k < SQRT_LAT; k++)
			p1_q[k] <= p1_q[k-1];
		p2_q[0] <= p2_in;
		for (int k = 1; k < DIV_LAT; k++)
			p2_q[k] <= p2_q[k-1];
	end

	// Valid chain: advance every cycle, drop all on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < SQRT_LAT; k++)
				v1_q[k] <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++)
				v2_q[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			v1_q[0] <= v_s2;
			for (int k = 1; k < SQRT_LAT; k++)
				v1_q[k] <= v1_q[k-1];
			v2_q[0] <= v1_q[SQRT_LAT-1];
			for (int k = 1; k < DIV_LAT; k++)
				v2_q[k] <= v2_q[k-1];
			done <= v2_q[DIV_LAT-1];
		end
	end

	// Output register: pick quotients or the early result, settle status
	always_ff @(posedge clk) begin
		logic             fdz, fov;
		logic [2:0][31:0] rv;
		logic [31:0]      sov;
		fdz = 1'b0;
		fov = p2_q[DIV_LAT-1].eov;
		rv  = p2_q[DIV_LAT-1].er;
		sov = p2_q[DIV_LAT-1].eso;
		case (p2_q[DIV_LAT-1].op)
			OP_SDIV, OP_EDIV, OP_NORM: begin
				sov = 32'd0;
				if (p2_q[DIV_LAT-1].op == OP_NORM && p2_q[DIV_LAT-1].lz) begin
					rv  = '0;
					fdz = 1'b1;
					fov = 1'b0;
				end else begin
					rv  = {dq[2], dq[1], dq[0]};
					fdz = ddz[0] | ddz[1] | ddz[2];
					fov = dov[0] | dov[1] | dov[2];
				end
			end
			default: fdz = 1'b0;
		endcase
		r_x        <= rv[0];
		r_y        <= rv[1];
		r_z        <= rv[2];
		scalar_out <= sov;
		status     <= fdz ? ST_DZ : (fov ? ST_SAT : ST_OK);
	end

`ifndef SYNTHESIS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##LATENCY done)
		else $error("result strobe missing after a start beat");
	a_noinv: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |-> ##LATENCY !done)
		else $error("result strobe without a start beat");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_DZ || status == ST_SAT))
		else $error("illegal status code");
`endif

endmodule

// ===== test/vec3_arithmetic_unit_core_tb.sv =====
// Self-checking testbench for the Q16.16 three-component vector unit.
`timescale 1ns / 1ps

module vec3_arithmetic_unit_core_tb import v3alu_pkg::*;;

	typedef struct {
		logic [3:0]         op;
		logic signed [31:0] ax, ay, az, bx, by, bz, sc, lo, hi;
		logic [1:0]         idx;
	} vec_beat_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, so;
		logic [1:0]         st;
	} vec_res_t;

	// Wide signed helpers for the predictor: exact products fit in 64 bits,
	// sums of three need a little headroom, so carry everything at 80 bits.
	typedef logic signed [79:0] wide_t;

	localparam wide_t W_MAX = 80'sd2147483647;
	localparam wide_t W_MIN = -80'sd2147483648;

	function automatic wide_t clip32(input wide_t v, inout bit ovf);
		if (v > W_MAX) begin
			ovf = 1;
			return W_MAX;
		end
		if (v < W_MIN) begin
			ovf = 1;
			return W_MIN;
		end
		return v;
	endfunction

	// Round a Q32.32 sum to Q16.16, nearest with ties away from zero.
	function automatic wide_t round_q32(input wide_t t, inout bit ovf);
		wide_t h;
		logic [15:0] l;
		h = t >>> 16;
		l = t[15:0];
		if (h >= 0)
			h = h + (l >= 16'h8000 ? 1 : 0);
		else
			h = h + (l > 16'h8000 ? 1 : 0);
		return clip32(h, ovf);
	endfunction

	function automatic wide_t quot_q(input wide_t a, input wide_t d, inout bit dz,
			inout bit ovf);
		wide_t n, un, ud, q;
		n = a * 65536;
		if (d == 0) begin
			dz = 1;
			return n > 0 ? W_MAX : (n < 0 ? W_MIN : 0);
		end
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (2 * un + ud) / (2 * ud);
		if ((n < 0) != (d < 0))
			q = -q;
		return clip32(q, ovf);
	endfunction

	function automatic wide_t vec_length(input wide_t x, input wide_t y, input wide_t z);
		logic [79:0] s, r, b, rem;
		s = x * x + y * y + z * z;
		rem = s;
		r = 0;
		b = 80'd1 << 78;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s > r * r + r)
			r = r + 1;
		return wide_t'(r);
	endfunction

	function automatic vec_res_t predict_vec(input vec_beat_t t);
		vec_res_t e;
		wide_t a[3], bb[3], r[3], so, ln;
		bit dz, ovf;
		a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
		bb[0] = t.bx; bb[1] = t.by; bb[2] = t.bz;
		r[0] = 0; r[1] = 0; r[2] = 0;
		so = 0; dz = 0; ovf = 0;
		case (t.op)
			OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clip32(a[i] + bb[i], ovf);
			OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clip32(a[i] - bb[i], ovf);
			OP_CROSS: begin
				r[0] = round_q32(a[1] * bb[2] - a[2] * bb[1], ovf);
				r[1] = round_q32(a[2] * bb[0] - a[0] * bb[2], ovf);
				r[2] = round_q32(a[0] * bb[1] - a[1] * bb[0], ovf);
			end
			OP_DOT:   so = round_q32(a[0] * bb[0] + a[1] * bb[1] + a[2] * bb[2], ovf);
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_q32(a[i] * t.sc, ovf);
			OP_SDIV:  for (int i = 0; i < 3; i++) r[i] = quot_q(a[i], t.sc, dz, ovf);
			OP_NEG:   for (int i = 0; i < 3; i++) r[i] = clip32(-a[i], ovf);
			OP_EMUL:  for (int i = 0; i < 3; i++) r[i] = round_q32(a[i] * bb[i], ovf);
			OP_EDIV:  for (int i = 0; i < 3; i++) r[i] = quot_q(a[i], bb[i], dz, ovf);
			OP_LENGTH: so = clip32(vec_length(a[0], a[1], a[2]), ovf);
			OP_NORM: begin
				ln = vec_length(a[0], a[1], a[2]);
				if (ln == 0)
					dz = 1;
				else
					for (int i = 0; i < 3; i++) r[i] = quot_q(a[i], ln, dz, ovf);
			end
			OP_CLAMP: begin
				for (int i = 0; i < 3; i++) r[i] = a[i];
				if (t.idx < 3) begin
					if (r[t.idx] < wide_t'(t.lo))
						r[t.idx] = t.lo;
					else if (r[t.idx] > wide_t'(t.hi))
						r[t.idx] = t.hi;
				end
			end
			default: ;
		endcase
		e.rx = r[0][31:0]; e.ry = r[1][31:0]; e.rz = r[2][31:0];
		e.so = so[31:0];
		e.st = dz ? ST_DZ : (ovf ? ST_SAT : ST_OK);
		return e;
	endfunction

	class vec_scoreboard;
		vec_res_t pending[$];
		int errors;
		int checked;

		function void note_beat(vec_beat_t t);
			pending.push_back(predict_vec(t));
		endfunction

		function void check_result(vec_res_t got);
			vec_res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.rx !== e.rx) begin
				$error("r_x exp %h got %h", e.rx, got.rx); errors++;
			end
			if (got.ry !== e.ry) begin
				$error("r_y exp %h got %h", e.ry, got.ry); errors++;
			end
			if (got.rz !== e.rz) begin
				$error("r_z exp %h got %h", e.rz, got.rz); errors++;
			end
			if (got.so !== e.so) begin
				$error("scalar_out exp %h got %h", e.so, got.so); errors++;
			end
			if (got.st !== e.st) begin
				$error("status exp %0d got %0d", e.st, got.st); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic [3:0] operation;
	logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar_in, lower_bound, upper_bound;
	logic [1:0] component_index;
	logic signed [31:0] r_x, r_y, r_z, scalar_out;
	logic [1:0] status;

	vec_scoreboard sb;
	int cycles;
	int op_hits[16];

	vec3_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .scalar_in(scalar_in),
		.component_index(component_index), .lower_bound(lower_bound),
		.upper_bound(upper_bound), .done(done), .r_x(r_x), .r_y(r_y),
		.r_z(r_z), .scalar_out(scalar_out), .status(status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Sample results on done; the receiver never stalls.
	always @(posedge clk) begin
		vec_res_t got;
		if (arst_n && done === 1'b1) begin
			got.rx = r_x; got.ry = r_y; got.rz = r_z;
			got.so = scalar_out; got.st = status;
			sb.check_result(got);
		end
	end

	// Watchdog: generous limit on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Random Q16.16 value with a bias towards edges and small magnitudes.
	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			4: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
			5: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return $urandom();
		endcase
	endfunction

	// Drive one beat and hold it until it is taken; start is left high.
	task automatic send_beat(input vec_beat_t t);
		operation <= t.op;
		a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
		b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
		scalar_in <= t.sc; component_index <= t.idx;
		lower_bound <= t.lo; upper_bound <= t.hi;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_beat(t);
		op_hits[t.op]++;
	endtask

	// Idle between beats: mostly none or short, now and then long.
	task automatic idle_gap(input bit calm);
		int n;
		if (calm)
			return;
		case ($urandom_range(0, 19))
			0: n = $urandom_range(20, 120);
			1, 2, 3, 4, 5, 6: n = $urandom_range(1, 4);
			default: n = 0;
		endcase
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic vec_beat_t rand_beat();
		vec_beat_t t;
		t.op = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
		t.ax = pick_val(); t.ay = pick_val(); t.az = pick_val();
		t.bx = pick_val(); t.by = pick_val(); t.bz = pick_val();
		t.sc = pick_val(); t.lo = pick_val(); t.hi = pick_val();
		t.idx = 2'($urandom_range(0, 3));
		if (t.op == OP_CLAMP && $urandom_range(0, 3) != 0 && t.lo > t.hi) begin
			logic signed [31:0] sw;
			sw = t.lo; t.lo = t.hi; t.hi = sw;
		end
		return t;
	endfunction

	function automatic vec_beat_t mk(input logic [3:0] op, input logic [31:0] av,
			input logic [31:0] bv, input logic [31:0] sv);
		vec_beat_t t;
		t.op = op;
		t.ax = av; t.ay = av; t.az = av;
		t.bx = bv; t.by = bv; t.bz = bv;
		t.sc = sv; t.idx = 2'd0;
		t.lo = 32'hFFFF_0000; t.hi = 32'h0001_0000;
		return t;
	endfunction

	initial begin
		vec_beat_t t;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		{a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		{scalar_in, lower_bound, upper_bound} = '0;
		component_index = 2'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, saturation at both limits, divide by zero,
		// zero-length normalize, clamp on each side, swapped bounds, index three
		// and two of the unused codes.
		send_beat(mk(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_beat(mk(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 0));
		send_beat(mk(OP_CROSS, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		t = mk(OP_CROSS, 32'h0002_0000, 32'h0003_0000, 0);
		t.ay = 32'hFFFE_8000; t.bz = 32'h0000_0001;
		send_beat(t);
		send_beat(mk(OP_DOT, 32'h8000_0000, 32'h8000_0000, 0));
		send_beat(mk(OP_DOT, 32'h0000_8000, 32'h0000_0001, 0));
		send_beat(mk(OP_SCALE, 32'h0001_8000, 0, 32'hFFFF_8000));
		send_beat(mk(OP_SDIV, 32'h0001_0000, 0, 0));
		t = mk(OP_SDIV, 32'hFFFF_0000, 0, 0); t.az = 0;
		send_beat(t);
		send_beat(mk(OP_SDIV, 32'h7FFF_FFFF, 0, 32'h0000_0001));
		send_beat(mk(OP_NEG, 32'h8000_0000, 0, 0));
		send_beat(mk(OP_EMUL, 32'hFFFF_FFFF, 32'h0000_8000, 0));
		send_beat(mk(OP_EDIV, 32'h0003_0000, 32'hFFFE_0000, 0));
		t = mk(OP_EDIV, 32'h8000_0000, 0, 0); t.bz = 32'h0000_0001;
		send_beat(t);
		send_beat(mk(OP_LENGTH, 32'h8000_0000, 0, 0));
		send_beat(mk(OP_LENGTH, 32'h0003_0000, 0, 0));
		send_beat(mk(OP_NORM, 0, 0, 0));
		send_beat(mk(OP_NORM, 32'h7FFF_FFFF, 0, 0));
		t = mk(OP_CLAMP, 32'h8000_0000, 0, 0); send_beat(t);
		t = mk(OP_CLAMP, 32'h7FFF_FFFF, 0, 0); t.idx = 2'd1; send_beat(t);
		t = mk(OP_CLAMP, 32'h7FFF_FFFF, 0, 0); t.idx = 2'd2;
		t.lo = 32'h0001_0000; t.hi = 32'hFFFF_0000; send_beat(t);
		t = mk(OP_CLAMP, 32'h8000_0000, 0, 0); t.idx = 2'd3; send_beat(t);
		send_beat(mk(4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_beat(mk(4'd15, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F));

		// Random: bursts with no idling alternate with gappy stretches.
		for (int i = 0; i < 850; i++) begin
			send_beat(rand_beat());
			idle_gap((i / 100) % 3 == 1);
		end
		start <= 1'b0;

		// Drain the pipeline, then allow the full latency for stray beats.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d results over all twelve operations and unused codes",
			sb.checked);
		$display("lengths %0d, normalizes %0d, divides %0d, clamps %0d",
			op_hits[OP_LENGTH], op_hits[OP_NORM], op_hits[OP_SDIV] + op_hits[OP_EDIV],
			op_hits[OP_CLAMP]);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/v3alu_pkg.sv
hw/rtl/v3alu_lane.sv
hw/rtl/v3alu_sqrt.sv
hw/rtl/v3alu_div.sv
hw/rtl/vec3_arithmetic_unit_core.sv
test/vec3_arithmetic_unit_core_tb.sv
